// ----- design/assert_macros.svh -----
// Assertion macros used by the design file stride_phase_rearrange_addr.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/spra_pkg.sv -----
package spra_pkg;

	localparam int MAX_STRIDE = 16;
	localparam int DIM_BITS = 12;
	localparam int INDEX_BITS = 32;

	localparam int STRIDE_BITS = $clog2(MAX_STRIDE + 1);
	localparam int PHASE_BITS = $clog2(MAX_STRIDE);
	localparam int BATCH_BITS = 8;
	localparam int CHAN_BITS = 10;
	localparam int BATCH_MAX = 1 << BATCH_BITS;
	localparam int CHAN_MAX = 1 << CHAN_BITS;
	localparam int DIM_MAX = 1 << DIM_BITS;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 13;
	localparam int SAMPLE_BITS = 32;
	localparam int DEST_BITS = 32;

	localparam int MODE_REG_BITS = 1;
	localparam int STRIDE_REG_BITS = 5;
	localparam int BATCH_REG_BITS = 9;
	localparam int CHAN_REG_BITS = 11;
	localparam int DIM_REG_BITS = 13;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODE,
		REG_STRIDE,
		REG_BATCH,
		REG_CHAN,
		REG_HEIGHT,
		REG_WIDTH
	} reg_idx_t;

	typedef struct packed {
		logic                  busy;
		logic [BATCH_BITS-1:0] n_last;
		logic [CHAN_BITS-1:0]  c_last;
		logic [DIM_BITS-1:0]   h_last;
		logic [DIM_BITS-1:0]   w_last;
		logic [PHASE_BITS-1:0] s_last;
		logic [INDEX_BITS-1:0] batch_step;
		logic [INDEX_BITS-1:0] chan_step;
		logic [INDEX_BITS-1:0] rreg_step;
		logic [INDEX_BITS-1:0] rphase_step;
		logic [INDEX_BITS-1:0] cphase_step;
	} geom_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0]  idx;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   done;
	} res_t;

endpackage

// ----- design/spra_cfg.sv -----
module spra_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [spra_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [spra_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output spra_pkg::geom_t                       geom
);
	import spra_pkg::*;

	localparam int DIV_BITS = ((DIM_BITS > PHASE_BITS) ? DIM_BITS : PHASE_BITS) + 2;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	localparam int REM_EXT = STRIDE_BITS + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_TOPH,
		ST_TOPW,
		ST_PLANE,
		ST_AREA,
		ST_CAREA,
		ST_SCAREA,
		ST_SSCAREA,
		ST_CPLANE,
		ST_RRTOPW
	} state_t;

	state_t                     state_q;
	logic [MODE_REG_BITS-1:0]   mode_q;
	logic [STRIDE_REG_BITS-1:0] stride_q;
	logic [BATCH_REG_BITS-1:0]  batch_q;
	logic [CHAN_REG_BITS-1:0]   chan_q;
	logic [DIM_REG_BITS-1:0]    height_q;
	logic [DIM_REG_BITS-1:0]    width_q;

	logic [DIV_BITS-1:0]        num_h_q, num_w_q;
	logic [STRIDE_BITS-1:0]     rem_h_q, rem_w_q;
	logic [DIV_CNT_BITS-1:0]    div_cnt_q;
	logic [INDEX_BITS-1:0]      top_h_q, top_w_q, plane_q, area_q, carea_q;
	logic [INDEX_BITS-1:0]      scarea_q, sscarea_q, cplane_q, rrtopw_q;

	logic [STRIDE_BITS-1:0]     eff_s;
	logic [BATCH_BITS:0]        eff_n;
	logic [CHAN_BITS:0]         eff_c;
	logic [DIM_BITS:0]          eff_h, eff_w;
	logic [DIV_BITS-1:0]        dvd_h, dvd_w;
	logic [REM_EXT-1:0]         t_h, t_w, sub_h, sub_w;
	logic                       ge_h, ge_w;
	logic [INDEX_BITS-1:0]      rr_x, rc_x, s_x, c_x;
	logic [INDEX_BITS-1:0]      mul_a, mul_b, mul_p;
	logic                       cfg_hit;

	always_comb begin
		if (32'(stride_q) < 2) begin
			eff_s = STRIDE_BITS'(2);
		end else if (32'(stride_q) > MAX_STRIDE) begin
			eff_s = STRIDE_BITS'(MAX_STRIDE);
		end else begin
			eff_s = STRIDE_BITS'(stride_q);
		end
		if (batch_q == '0) begin
			eff_n = (BATCH_BITS+1)'(1);
		end else if (32'(batch_q) > BATCH_MAX) begin
			eff_n = (BATCH_BITS+1)'(BATCH_MAX);
		end else begin
			eff_n = (BATCH_BITS+1)'(batch_q);
		end
		if (chan_q == '0) begin
			eff_c = (CHAN_BITS+1)'(1);
		end else if (32'(chan_q) > CHAN_MAX) begin
			eff_c = (CHAN_BITS+1)'(CHAN_MAX);
		end else begin
			eff_c = (CHAN_BITS+1)'(chan_q);
		end
		if (height_q == '0) begin
			eff_h = (DIM_BITS+1)'(1);
		end else if (32'(height_q) > DIM_MAX) begin
			eff_h = (DIM_BITS+1)'(DIM_MAX);
		end else begin
			eff_h = (DIM_BITS+1)'(height_q);
		end
		if (width_q == '0) begin
			eff_w = (DIM_BITS+1)'(1);
		end else if (32'(width_q) > DIM_MAX) begin
			eff_w = (DIM_BITS+1)'(DIM_MAX);
		end else begin
			eff_w = (DIM_BITS+1)'(width_q);
		end
	end

	assign dvd_h = DIV_BITS'(eff_h) + DIV_BITS'(eff_s) - DIV_BITS'(1);
	assign dvd_w = DIV_BITS'(eff_w) + DIV_BITS'(eff_s) - DIV_BITS'(1);

	assign t_h = {rem_h_q, num_h_q[DIV_BITS-1]};
	assign t_w = {rem_w_q, num_w_q[DIV_BITS-1]};
	assign ge_h = t_h >= REM_EXT'(eff_s);
	assign ge_w = t_w >= REM_EXT'(eff_s);
	assign sub_h = t_h - REM_EXT'(eff_s);
	assign sub_w = t_w - REM_EXT'(eff_s);

	assign rr_x = INDEX_BITS'(num_h_q[DIM_BITS-1:0]);
	assign rc_x = INDEX_BITS'(num_w_q[DIM_BITS-1:0]);
	assign s_x = INDEX_BITS'(eff_s);
	assign c_x = INDEX_BITS'(eff_c);

	always_comb begin
		unique case (state_q)
			ST_TOPH: begin
				mul_a = rr_x;
				mul_b = s_x;
			end
			ST_TOPW: begin
				mul_a = rc_x;
				mul_b = s_x;
			end
			ST_PLANE: begin
				mul_a = top_h_q;
				mul_b = top_w_q;
			end
			ST_AREA: begin
				mul_a = rr_x;
				mul_b = rc_x;
			end
			ST_CAREA: begin
				mul_a = c_x;
				mul_b = area_q;
			end
			ST_SCAREA: begin
				mul_a = s_x;
				mul_b = carea_q;
			end
			ST_SSCAREA: begin
				mul_a = s_x;
				mul_b = scarea_q;
			end
			ST_CPLANE: begin
				mul_a = c_x;
				mul_b = plane_q;
			end
			ST_RRTOPW: begin
				mul_a = rr_x;
				mul_b = top_w_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = INDEX_BITS'(mul_a * mul_b);
	assign cfg_hit = cfg_we && (cfg_index <= REG_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			mode_q    <= '0;
			stride_q  <= STRIDE_REG_BITS'(2);
			batch_q   <= BATCH_REG_BITS'(1);
			chan_q    <= CHAN_REG_BITS'(1);
			height_q  <= DIM_REG_BITS'(1);
			width_q   <= DIM_REG_BITS'(1);
			num_h_q   <= '0;
			num_w_q   <= '0;
			rem_h_q   <= '0;
			rem_w_q   <= '0;
			div_cnt_q <= '0;
			top_h_q   <= '0;
			top_w_q   <= '0;
			plane_q   <= '0;
			area_q    <= '0;
			carea_q   <= '0;
			scarea_q  <= '0;
			sscarea_q <= '0;
			cplane_q  <= '0;
			rrtopw_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:   mode_q <= cfg_data[MODE_REG_BITS-1:0];
					REG_STRIDE: stride_q <= cfg_data[STRIDE_REG_BITS-1:0];
					REG_BATCH:  batch_q <= cfg_data[BATCH_REG_BITS-1:0];
					REG_CHAN:   chan_q <= cfg_data[CHAN_REG_BITS-1:0];
					REG_HEIGHT: height_q <= cfg_data[DIM_REG_BITS-1:0];
					REG_WIDTH:  width_q <= cfg_data[DIM_REG_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (cfg_hit) begin
				state_q <= ST_LOAD;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
					end
					ST_LOAD: begin
						num_h_q   <= dvd_h;
						num_w_q   <= dvd_w;
						rem_h_q   <= '0;
						rem_w_q   <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
					ST_DIV: begin
						num_h_q <= {num_h_q[DIV_BITS-2:0], ge_h};
						num_w_q <= {num_w_q[DIV_BITS-2:0], ge_w};
						rem_h_q <= ge_h ? sub_h[STRIDE_BITS-1:0] : t_h[STRIDE_BITS-1:0];
						rem_w_q <= ge_w ? sub_w[STRIDE_BITS-1:0] : t_w[STRIDE_BITS-1:0];
						if (div_cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
							state_q <= ST_TOPH;
						end else begin
							div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
						end
					end
					ST_TOPH: begin
						top_h_q <= mul_p;
						state_q <= ST_TOPW;
					end
					ST_TOPW: begin
						top_w_q <= mul_p;
						state_q <= ST_PLANE;
					end
					ST_PLANE: begin
						plane_q <= mul_p;
						state_q <= ST_AREA;
					end
					ST_AREA: begin
						area_q  <= mul_p;
						state_q <= ST_CAREA;
					end
					ST_CAREA: begin
						carea_q <= mul_p;
						state_q <= ST_SCAREA;
					end
					ST_SCAREA: begin
						scarea_q <= mul_p;
						state_q  <= ST_SSCAREA;
					end
					ST_SSCAREA: begin
						sscarea_q <= mul_p;
						state_q   <= ST_CPLANE;
					end
					ST_CPLANE: begin
						cplane_q <= mul_p;
						state_q  <= ST_RRTOPW;
					end
					ST_RRTOPW: begin
						rrtopw_q <= mul_p;
						state_q  <= ST_IDLE;
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

	always_comb begin
		geom.busy   = state_q != ST_IDLE;
		geom.n_last = BATCH_BITS'(eff_n - (BATCH_BITS+1)'(1));
		geom.c_last = CHAN_BITS'(eff_c - (CHAN_BITS+1)'(1));
		geom.h_last = DIM_BITS'(eff_h - (DIM_BITS+1)'(1));
		geom.w_last = DIM_BITS'(eff_w - (DIM_BITS+1)'(1));
		geom.s_last = PHASE_BITS'(eff_s - STRIDE_BITS'(1));
		if (mode_q[0]) begin
			geom.batch_step  = sscarea_q;
			geom.chan_step   = area_q;
			geom.rreg_step   = rc_x;
			geom.rphase_step = scarea_q;
			geom.cphase_step = carea_q;
		end else begin
			geom.batch_step  = cplane_q;
			geom.chan_step   = plane_q;
			geom.rreg_step   = top_w_q;
			geom.rphase_step = rrtopw_q;
			geom.cphase_step = rc_x;
		end
	end

endmodule

// ----- design/spra_idx.sv -----
module spra_idx (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spra_pkg::geom_t                    geom,
	input  logic                               elem_valid,
	output logic                               elem_ready,
	input  logic [spra_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic                               restart,
	input  logic                               s1_take,
	output logic                               s1_valid,
	output spra_pkg::res_t                     s1_res
);
	import spra_pkg::*;

	logic                  valid_s1;
	res_t                  res_s1;
	logic                  accept;

	logic [BATCH_BITS-1:0] batch_q, batch_c, batch_n;
	logic [CHAN_BITS-1:0]  chan_q, chan_c, chan_n;
	logic [DIM_BITS-1:0]   row_q, row_c, row_n;
	logic [DIM_BITS-1:0]   col_q, col_c, col_n;
	logic [PHASE_BITS-1:0] rphase_q, rphase_c, rphase_n;
	logic [PHASE_BITS-1:0] cphase_q, cphase_c, cphase_n;
	logic [DIM_BITS-1:0]   creg_q, creg_c, creg_n;
	logic [INDEX_BITS-1:0] bat_off_q, bat_off_c, bat_off_n;
	logic [INDEX_BITS-1:0] chan_off_q, chan_off_c, chan_off_n;
	logic [INDEX_BITS-1:0] rreg_off_q, rreg_off_c, rreg_off_n;
	logic [INDEX_BITS-1:0] row_off_q, row_off_c, row_off_n;
	logic [INDEX_BITS-1:0] col_off_q, col_off_c, col_off_n;
	logic [INDEX_BITS-1:0] idx;
	logic                  done;

	assign elem_ready = !geom.busy && (!valid_s1 || s1_take);
	assign accept = elem_valid && elem_ready;

	// A restart places the element as though all counters were cleared.
	always_comb begin
		batch_c    = restart ? '0 : batch_q;
		chan_c     = restart ? '0 : chan_q;
		row_c      = restart ? '0 : row_q;
		col_c      = restart ? '0 : col_q;
		rphase_c   = restart ? '0 : rphase_q;
		cphase_c   = restart ? '0 : cphase_q;
		creg_c     = restart ? '0 : creg_q;
		bat_off_c  = restart ? '0 : bat_off_q;
		chan_off_c = restart ? '0 : chan_off_q;
		rreg_off_c = restart ? '0 : rreg_off_q;
		row_off_c  = restart ? '0 : row_off_q;
		col_off_c  = restart ? '0 : col_off_q;
	end

	assign idx = bat_off_c + chan_off_c + row_off_c + col_off_c;
	assign done = (batch_c == geom.n_last) && (chan_c == geom.c_last) &&
		(row_c == geom.h_last) && (col_c == geom.w_last);

	always_comb begin
		batch_n    = batch_c;
		chan_n     = chan_c;
		row_n      = row_c;
		col_n      = col_c;
		rphase_n   = rphase_c;
		cphase_n   = cphase_c;
		creg_n     = creg_c;
		bat_off_n  = bat_off_c;
		chan_off_n = chan_off_c;
		rreg_off_n = rreg_off_c;
		row_off_n  = row_off_c;
		col_off_n  = col_off_c;
		if (col_c != geom.w_last) begin
			col_n = col_c + DIM_BITS'(1);
			if (cphase_c == geom.s_last) begin
				cphase_n  = '0;
				creg_n    = creg_c + DIM_BITS'(1);
				col_off_n = INDEX_BITS'(creg_c) + INDEX_BITS'(1);
			end else begin
				cphase_n  = cphase_c + PHASE_BITS'(1);
				col_off_n = col_off_c + geom.cphase_step;
			end
		end else begin
			col_n     = '0;
			cphase_n  = '0;
			creg_n    = '0;
			col_off_n = '0;
			if (row_c != geom.h_last) begin
				row_n = row_c + DIM_BITS'(1);
				if (rphase_c == geom.s_last) begin
					rphase_n   = '0;
					rreg_off_n = rreg_off_c + geom.rreg_step;
					row_off_n  = rreg_off_c + geom.rreg_step;
				end else begin
					rphase_n  = rphase_c + PHASE_BITS'(1);
					row_off_n = row_off_c + geom.rphase_step;
				end
			end else begin
				row_n      = '0;
				rphase_n   = '0;
				rreg_off_n = '0;
				row_off_n  = '0;
				if (chan_c != geom.c_last) begin
					chan_n     = chan_c + CHAN_BITS'(1);
					chan_off_n = chan_off_c + geom.chan_step;
				end else begin
					chan_n     = '0;
					chan_off_n = '0;
					if (batch_c != geom.n_last) begin
						batch_n   = batch_c + BATCH_BITS'(1);
						bat_off_n = bat_off_c + geom.batch_step;
					end else begin
						batch_n   = '0;
						bat_off_n = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			batch_q    <= '0;
			chan_q     <= '0;
			row_q      <= '0;
			col_q      <= '0;
			rphase_q   <= '0;
			cphase_q   <= '0;
			creg_q     <= '0;
			bat_off_q  <= '0;
			chan_off_q <= '0;
			rreg_off_q <= '0;
			row_off_q  <= '0;
			col_off_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
			if (geom.busy) begin
				batch_q    <= '0;
				chan_q     <= '0;
				row_q      <= '0;
				col_q      <= '0;
				rphase_q   <= '0;
				cphase_q   <= '0;
				creg_q     <= '0;
				bat_off_q  <= '0;
				chan_off_q <= '0;
				rreg_off_q <= '0;
				row_off_q  <= '0;
				col_off_q  <= '0;
			end else if (accept) begin
				batch_q    <= batch_n;
				chan_q     <= chan_n;
				row_q      <= row_n;
				col_q      <= col_n;
				rphase_q   <= rphase_n;
				cphase_q   <= cphase_n;
				creg_q     <= creg_n;
				bat_off_q  <= bat_off_n;
				chan_off_q <= chan_off_n;
				rreg_off_q <= rreg_off_n;
				row_off_q  <= row_off_n;
				col_off_q  <= col_off_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.idx    <= idx;
			res_s1.sample <= sample;
			res_s1.done   <= done;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_res = res_s1;

endmodule

// ----- design/spra_oreg.sv -----
module spra_oreg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s1_valid,
	input  spra_pkg::res_t  s1_res,
	output logic            s1_take,
	output logic            result_valid,
	input  logic            result_ready,
	output spra_pkg::res_t  result
);
	import spra_pkg::*;

	logic valid_s2;
	res_t res_s2;

	assign s1_take = s1_valid && (!valid_s2 || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_take) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			res_s2 <= s1_res;
		end
	end

	assign result_valid = valid_s2;
	assign result = res_s2;

endmodule

// ----- design/stride_phase_rearrange_addr.sv -----
// Stride-phase rearrangement address generator.
// Tensor elements enter on the elem channel (sample, restart) in raster order, one
// transfer per element. Each element leaves on the result channel with its
// destination index in the rearranged tensor and a flag on the last element.
// Restart high on a transfer makes that element the first of a new tensor.
// Registers are written through cfg_we, cfg_index and cfg_data. After reset and
// after every write to a known register, a setup pass computes the region sizes
// (a shift-subtract divider) and the index strides (nine products on one
// shared multiplier); elem_ready stays low meanwhile and the position
// counters are cleared. Once set up, the block takes one element per cycle
// while the results are taken. Each element passes through a stage register
// and then the result register, which drives result_valid. The two registers
// hold two elements, so while the receiver stalls elements are taken only
// until both are full; after that elem_ready drops until result_ready returns.
module stride_phase_rearrange_addr (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                elem_valid,
	output logic                                elem_ready,
	input  logic [spra_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                restart,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [spra_pkg::DEST_BITS-1:0]      dest_index,
	output logic [spra_pkg::SAMPLE_BITS-1:0]    sample_out,
	output logic                                tensor_done,
	input  logic                                cfg_we,
	input  logic [spra_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [spra_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import spra_pkg::*;

	`include "assert_macros.svh"

	geom_t geom;
	logic  s1_valid;
	res_t  s1_res;
	logic  s1_take;
	res_t  result;
	logic  restart_take;

	spra_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	spra_idx u_idx (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.sample     (sample),
		.restart    (restart),
		.s1_take    (s1_take),
		.s1_valid   (s1_valid),
		.s1_res     (s1_res)
	);

	spra_oreg u_oreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1_res       (s1_res),
		.s1_take      (s1_take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	assign dest_index = DEST_BITS'(result.idx);
	assign sample_out = result.sample;
	assign tensor_done = result.done;

	assign restart_take = elem_valid && elem_ready && restart;

	`ASSERT_IMPLY(a_no_transfer_in_setup, clk, arst_n, elem_valid && elem_ready, !geom.busy)
	`ASSERT_NEXT(a_write_starts_setup, clk, arst_n, cfg_we && (cfg_index <= REG_WIDTH), !elem_ready)
	`ASSERT_NEXT(a_restart_index_zero, clk, arst_n, restart_take, s1_valid && (s1_res.idx == '0))

endmodule

// ----- verif/stride_phase_rearrange_addr_check.sv -----
module stride_phase_rearrange_addr_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                elem_valid,
	input  logic                                elem_ready,
	input  logic [spra_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                restart,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic [spra_pkg::DEST_BITS-1:0]      dest_index,
	input  logic [spra_pkg::SAMPLE_BITS-1:0]    sample_out,
	input  logic                                tensor_done,
	input  logic                                cfg_we,
	input  logic [spra_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [spra_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                  failures,
	output int                                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import spra_pkg::*;

	typedef enum logic {
		LAYOUT_UNION = 1'b0,
		LAYOUT_SPLIT = 1'b1
	} layout_t;

	typedef struct {
		logic [DEST_BITS-1:0]   dest;
		logic [SAMPLE_BITS-1:0] word;
		logic                   last;
	} placement_t;

	placement_t placements_due[$];

	layout_t layout;
	logic [STRIDE_REG_BITS-1:0] stride_reg;
	logic [BATCH_REG_BITS-1:0]  batch_reg;
	logic [CHAN_REG_BITS-1:0]   chan_reg;
	logic [DIM_REG_BITS-1:0]    height_reg;
	logic [DIM_REG_BITS-1:0]    width_reg;

	int unsigned step_eff, images_eff, chans_eff, rows_eff, cols_eff;
	logic [DIM_BITS-1:0] region_rows, region_cols;

	logic [BATCH_BITS-1:0] img_at;
	logic [CHAN_BITS-1:0]  chan_at;
	logic [DIM_BITS-1:0]   row_at, col_at;
	logic [PHASE_BITS-1:0] row_phase, col_phase;
	logic [DIM_BITS-1:0]   row_region, col_region;

	int mismatch_total = 0;

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic home_counters();
		img_at = '0;
		chan_at = '0;
		row_at = '0;
		col_at = '0;
		row_phase = '0;
		col_phase = '0;
		row_region = '0;
		col_region = '0;
	endtask

	task automatic derive_geometry();
		step_eff = clip(stride_reg, 2, MAX_STRIDE);
		images_eff = clip(batch_reg, 1, BATCH_MAX);
		chans_eff = clip(chan_reg, 1, CHAN_MAX);
		rows_eff = clip(height_reg, 1, DIM_MAX);
		cols_eff = clip(width_reg, 1, DIM_MAX);
		region_rows = DIM_BITS'((rows_eff + step_eff - 1) / step_eff);
		region_cols = DIM_BITS'((cols_eff + step_eff - 1) / step_eff);
		home_counters();
	endtask

	task automatic restore_defaults();
		layout = LAYOUT_UNION;
		stride_reg = 2;
		batch_reg = 1;
		chan_reg = 1;
		height_reg = 1;
		width_reg = 1;
		derive_geometry();
	endtask

	task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			REG_MODE: layout = layout_t'(val[0]);
			REG_STRIDE: stride_reg = val[STRIDE_REG_BITS-1:0];
			REG_BATCH: batch_reg = val[BATCH_REG_BITS-1:0];
			REG_CHAN: chan_reg = val[CHAN_REG_BITS-1:0];
			REG_HEIGHT: height_reg = val[DIM_REG_BITS-1:0];
			REG_WIDTH: width_reg = val[DIM_REG_BITS-1:0];
			default: return;
		endcase
		derive_geometry();
	endtask

	task automatic place_element(input logic [SAMPLE_BITS-1:0] word, input logic fresh);
		longint unsigned s, rr, rc, c, top_h, top_w, orow, ocol, grp, idx;
		placement_t p;
		if (fresh)
			home_counters();
		s = step_eff;
		rr = region_rows;
		rc = region_cols;
		c = chans_eff;
		if (layout == LAYOUT_UNION) begin
			top_h = rr * s;
			top_w = rc * s;
			orow = row_region + row_phase * rr;
			ocol = col_region + col_phase * rc;
			idx = (((img_at * c + chan_at) * top_h + orow) * top_w) + ocol;
		end else begin
			grp = row_phase * s + col_phase;
			idx = (((img_at * s * s + grp) * c + chan_at) * rr * rc)
				+ row_region * rc + col_region;
		end
		p.dest = DEST_BITS'(idx);
		p.word = word;
		p.last = (img_at == images_eff - 1) && (chan_at == chans_eff - 1)
			&& (row_at == rows_eff - 1) && (col_at == cols_eff - 1);
		placements_due.insert(placements_due.size(), p);

		// Raster order: column, then row, then channel, then image.
		if (col_at + 1 < cols_eff) begin
			col_at++;
			if (col_phase + 1 == step_eff) begin
				col_phase = '0;
				col_region++;
			end else begin
				col_phase++;
			end
		end else begin
			col_at = '0;
			col_phase = '0;
			col_region = '0;
			if (row_at + 1 < rows_eff) begin
				row_at++;
				if (row_phase + 1 == step_eff) begin
					row_phase = '0;
					row_region++;
				end else begin
					row_phase++;
				end
			end else begin
				row_at = '0;
				row_phase = '0;
				row_region = '0;
				if (chan_at + 1 < chans_eff) begin
					chan_at++;
				end else begin
					chan_at = '0;
					if (img_at + 1 < images_eff)
						img_at++;
					else
						img_at = '0;
				end
			end
		end
	endtask

	task automatic judge_result();
		placement_t want;
		if (placements_due.size() == 0) begin
			$display("%0t: unexpected result transfer, dest_index %h sample_out %h",
				$time, dest_index, sample_out);
			mismatch_total++;
			return;
		end
		want = placements_due.pop_front();
		if (dest_index !== want.dest) begin
			$display("%0t: dest_index expected %h, actual %h", $time, want.dest, dest_index);
			mismatch_total++;
		end
		if (sample_out !== want.word) begin
			$display("%0t: sample_out expected %h, actual %h", $time, want.word, sample_out);
			mismatch_total++;
		end
		if (tensor_done !== want.last) begin
			$display("%0t: tensor_done expected %b, actual %b", $time, want.last, tensor_done);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_defaults();
			placements_due.delete();
		end else begin
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (elem_valid && elem_ready)
				place_element(sample, restart);
			if (result_valid && result_ready)
				judge_result();
		end
		failures <= mismatch_total;
		outstanding <= placements_due.size();
	end

endmodule

// ----- verif/stride_phase_rearrange_addr_test.sv -----
module stride_phase_rearrange_addr_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spra_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 850;
	localparam logic [CFG_INDEX_BITS-1:0] REG_VACANT_LO = CFG_INDEX_BITS'(6);
	localparam logic [CFG_INDEX_BITS-1:0] REG_VACANT_HI = CFG_INDEX_BITS'(7);

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_BEAT,
		RX_STALLS
	} rx_style_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      elem_valid;
	logic                      elem_ready;
	logic [SAMPLE_BITS-1:0]    sample;
	logic                      restart;
	logic                      result_valid;
	logic                      result_ready;
	logic [DEST_BITS-1:0]      dest_index;
	logic [SAMPLE_BITS-1:0]    sample_out;
	logic                      tensor_done;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int burst_left = 0;
	bit tx_steady = 1'b0;
	rx_style_t rx_style = RX_OPEN;
	int rx_tick = 0;
	int rx_hold = 0;

	stride_phase_rearrange_addr uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.sample(sample),
		.restart(restart),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.dest_index(dest_index),
		.sample_out(sample_out),
		.tensor_done(tensor_done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	stride_phase_rearrange_addr_check placement_check (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.sample(sample),
		.restart(restart),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.dest_index(dest_index),
		.sample_out(sample_out),
		.tensor_done(tensor_done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("stride_phase_rearrange_addr regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN: result_ready <= 1'b1;
				RX_COIN: result_ready <= ($urandom_range(0, 99) < 60);
				RX_BEAT: result_ready <= ((rx_tick % 9) < 5);
				default: begin
					if (rx_hold > 0) begin
						rx_hold <= rx_hold - 1;
						result_ready <= 1'b0;
					end else if ($urandom_range(0, 9) == 0) begin
						rx_hold <= $urandom_range(1, 15);
						result_ready <= 1'b0;
					end else begin
						result_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	function automatic logic [CFG_DATA_BITS-1:0] reg_pick(int lo, int hi, int top, int mask);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return CFG_DATA_BITS'(top);
			2: return CFG_DATA_BITS'($urandom_range(top + 1, mask));
			3: return CFG_DATA_BITS'($urandom_range(0, (1 << CFG_DATA_BITS) - 1));
			4: return CFG_DATA_BITS'(lo - 1);
			default: return CFG_DATA_BITS'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic push_elem(input logic [SAMPLE_BITS-1:0] word, input logic fresh);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = tx_steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				elem_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		elem_valid <= 1'b1;
		sample <= word;
		restart <= fresh;
		do @(posedge clk); while (elem_ready !== 1'b1);
	endtask

	// Write a register only once every result is out and setup is over; the block does not enforce it.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		elem_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (elem_ready !== 1'b1) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int random_sent;
		int phase_items;
		random_sent = 0;
		arst_n <= 1'b0;
		elem_valid <= 1'b0;
		sample <= '0;
		restart <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (elem_ready !== 1'b1) @(posedge clk);

		push_elem(32'h0000_0000, 1'b0);
		push_elem(32'hFFFF_FFFF, 1'b1);
		push_elem(32'hA5A5_A5A5, 1'b0);
		push_elem(32'h5A5A_5A5A, 1'b1);

		write_reg(REG_MODE, 13'd1);
		write_reg(REG_STRIDE, 13'd2);
		write_reg(REG_BATCH, 13'd2);
		write_reg(REG_CHAN, 13'd1);
		write_reg(REG_HEIGHT, 13'd2);
		write_reg(REG_WIDTH, 13'd3);
		for (int k = 0; k < 13; k++)
			push_elem($urandom, 1'b0);

		write_reg(REG_MODE, 13'h1FFE);
		write_reg(REG_STRIDE, 13'h0000);
		write_reg(REG_STRIDE, 13'h1FFF);
		write_reg(REG_BATCH, 13'h0000);
		write_reg(REG_CHAN, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'h1FFF);
		write_reg(REG_WIDTH, 13'h0000);
		write_reg(REG_VACANT_LO, 13'h1FFF);
		write_reg(REG_VACANT_HI, 13'h0AAA);
		for (int k = 0; k < 6; k++)
			push_elem($urandom, k == 3);

		while (random_sent < RANDOM_ITEMS) begin
			phase_items = $urandom_range(40, 90);
			rx_style <= rx_style_t'($urandom_range(0, 3));
			tx_steady = ($urandom_range(0, 3) == 0);
			write_reg(REG_MODE, CFG_DATA_BITS'($urandom_range(0, (1 << CFG_DATA_BITS) - 1)));
			write_reg(REG_STRIDE, reg_pick(2, 6, MAX_STRIDE, (1 << STRIDE_REG_BITS) - 1));
			write_reg(REG_BATCH, reg_pick(1, 3, BATCH_MAX, (1 << BATCH_REG_BITS) - 1));
			write_reg(REG_CHAN, reg_pick(1, 4, CHAN_MAX, (1 << CHAN_REG_BITS) - 1));
			write_reg(REG_HEIGHT, reg_pick(1, 12, DIM_MAX, (1 << DIM_REG_BITS) - 1));
			write_reg(REG_WIDTH, reg_pick(1, 12, DIM_MAX, (1 << DIM_REG_BITS) - 1));
			if ($urandom_range(0, 3) == 0)
				write_reg(($urandom_range(0, 1) == 0) ? REG_VACANT_LO : REG_VACANT_HI,
					CFG_DATA_BITS'($urandom_range(0, (1 << CFG_DATA_BITS) - 1)));
			for (int k = 0; k < phase_items; k++)
				push_elem($urandom, (k == 0) ? 1'($urandom_range(0, 1))
					: ($urandom_range(0, 39) == 0));
			random_sent += phase_items;
		end

		elem_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("stride_phase_rearrange_addr regression: pass");
		else
			$display("stride_phase_rearrange_addr regression: fail");
		$finish;
	end

endmodule
